/* hdl/tcb_pkg.sv */
// Shared types, constants and helpers for the cascading prescaled timer bank.
// No dependencies; used by tcb_div and cascading_prescaled_timer_bank_core.
`timescale 1ns / 1ps
`default_nettype none
package tcb_pkg;

	localparam int NUM_CHANNELS = 4;
	localparam int CNT_W = 16;   // counter / reload width
	localparam int RES_W = 11;   // signed prescale residue
	localparam int INC_W = 17;   // increment, threshold and overflow count width
	localparam int EST_W = 27;   // ticks-until-irq estimate width
	localparam int IN_W = 32;    // s_tdata width
	localparam int OUT_W = 72;   // m_tdata width

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_RUN   = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		OFF_LO   = 2'd0,
		OFF_HI   = 2'd1,
		OFF_CTRL = 2'd2,
		OFF_NONE = 2'd3
	} off_t;

	// prescaler: 1, 64, 256, 1024 ticks per count
	function automatic logic [3:0] tick_shift(input logic [1:0] sel);
		logic [3:0] s;
		case (sel)
			2'd0: s = 4'd0;
			2'd1: s = 4'd6;
			2'd2: s = 4'd8;
			default: s = 4'd10;
		endcase
		return s;
	endfunction

	function automatic logic [9:0] tick_mask(input logic [1:0] sel);
		logic [9:0] m;
		case (sel)
			2'd0: m = 10'h000;
			2'd1: m = 10'h03F;
			2'd2: m = 10'h0FF;
			default: m = 10'h3FF;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

/* hdl/tcb_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on tcb_pkg for the default width.
`timescale 1ns / 1ps
`default_nettype none
module tcb_div #(
	parameter int W = tcb_pkg::INC_W
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              busy,
	output logic              done,
	output logic [W-1:0]      quot,
	output logic [W-1:0]      rem
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  q_q, r_q, d_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [W:0]    sh, diff;

	assign sh = {r_q, q_q[W-1]};
	assign diff = sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			if (!diff[W]) begin
				r_q <= diff[W-1:0];
				q_q <= {q_q[W-2:0], 1'b1};
			end else begin
				r_q <= sh[W-1:0];
				q_q <= {q_q[W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = q_q;
	assign rem = r_q;

endmodule
`default_nettype wire

/* hdl/cascading_prescaled_timer_bank_core.sv */
// Top level of the cascading prescaled timer bank: sequencer, timer state, output register.
// Depends on tcb_pkg and tcb_div.
`timescale 1ns / 1ps
`default_nettype none
// A bank of NumChannels 16-bit up-counting timers with prescalers and a cascade chain.
// Each input beat is a byte register read, a byte register write or a run of run_ticks
// clock ticks, and yields one output beat. One sequencer visits the channels one at a
// time and drives a shared 17-bit subtract/compare path plus one iterative divider.
// A read, write or idle operation does the access, then scans each channel in turn for
// the next interrupt. A run visits each channel in turn (S_RUN, S_ADV when it advances,
// S_REC), and a channel that wraps more than once also waits in S_DIV while the divider
// works out the reload spans crossed, one quotient bit a cycle; then comes the same scan.
// s_tready is low while an item is in work; the next beat is taken only once the output
// register is empty or its result is being taken.
module cascading_prescaled_timer_bank_core #(
	parameter int NumChannels = tcb_pkg::NUM_CHANNELS
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	// [1:0] operation, [3:2] channel, [5:4] offset, [13:6] write_data, [29:14] run_ticks
	input  wire logic [tcb_pkg::IN_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	// [7:0] read_data, [11:8] irq_raised, [27:12] overflows_timer0,
	// [43:28] overflows_timer1, [44] irq_due_valid, [71:45] cycles_until_irq
	output logic [tcb_pkg::OUT_W-1:0]     m_tdata
);

	localparam int CW = (NumChannels > 1) ? $clog2(NumChannels) : 1;
	localparam int IW = tcb_pkg::INC_W;
	localparam int EW = tcb_pkg::EST_W;
	localparam int RW = tcb_pkg::RES_W;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_ACC  = 7'b0000010,
		S_RUN  = 7'b0000100,
		S_ADV  = 7'b0001000,
		S_DIV  = 7'b0010000,
		S_REC  = 7'b0100000,
		S_EST  = 7'b1000000
	} state_t;

	state_t state_q;

	logic [15:0]   reload_q [NumChannels];
	logic [15:0]   count_q  [NumChannels];
	logic [RW-1:0] res_q    [NumChannels];
	logic [1:0]    psel_q   [NumChannels];
	logic          casc_q   [NumChannels];
	logic          irqen_q  [NumChannels];
	logic          en_q     [NumChannels];

	logic [CW-1:0] ch_q;
	logic          addr_ok_q;
	tcb_pkg::op_t  op_q;
	tcb_pkg::off_t off_q;
	logic [7:0]    wdata_q;
	logic [15:0]   ticks_q;
	logic [IW-1:0] inc_q, carry_q, ovf_q;
	logic [7:0]    rd_q;
	logic [3:0]    irq_q;
	logic [15:0]   ovf0_q, ovf1_q;
	logic          best_ok_q;
	logic [EW-1:0] best_q;
	logic          m_valid_q;
	logic [tcb_pkg::OUT_W-1:0] m_data_q;

	logic          accept, last_ch;
	logic [1:0]    in_op, in_ch, in_off;

	// per-channel views at the sequencer address
	logic [15:0]   cur_cnt, cur_rel;
	logic [RW-1:0] cur_res;
	logic [1:0]    cur_sel;
	logic [3:0]    cur_shift;
	logic          cur_due;
	logic [17:0]   avail;
	logic [IW-1:0] thr, thr_rel, rem_inc;
	logic [IW-1:0] cnt_ext;
	logic [EW-1:0] span_sh;
	logic [EW:0]   need;
	logic [EW-1:0] need_sat;

	logic          div_start, div_busy, div_done;
	logic [IW-1:0] div_quot, div_rem;

	assign in_op = s_tdata[1:0];
	assign in_ch = s_tdata[3:2];
	assign in_off = s_tdata[5:4];

	assign s_tready = (state_q == S_IDLE) && (!m_valid_q || m_tready);
	assign accept = s_tvalid && s_tready;
	assign last_ch = (ch_q == CW'(NumChannels - 1));

	assign cur_cnt = count_q[ch_q];
	assign cur_rel = reload_q[ch_q];
	assign cur_res = res_q[ch_q];
	assign cur_sel = psel_q[ch_q];
	assign cur_shift = tcb_pkg::tick_shift(cur_sel);
	assign cur_due = irqen_q[ch_q] && en_q[ch_q] && !casc_q[ch_q];

	assign avail = {{(18 - RW){cur_res[RW-1]}}, cur_res} + {2'b00, ticks_q};
	assign cnt_ext = {1'b0, cur_cnt};
	assign thr = 17'h10000 - cnt_ext;
	assign thr_rel = 17'h10000 - {1'b0, cur_rel};
	assign rem_inc = inc_q - thr;

	assign span_sh = EW'(thr) << cur_shift;
	assign need = {1'b0, span_sh} - {{(EW + 1 - RW){cur_res[RW-1]}}, cur_res};
	assign need_sat = need[EW] ? '0 : need[EW-1:0];

	assign div_start = (state_q == S_ADV) && (inc_q >= thr) && (rem_inc >= thr_rel);

	tcb_div #(.W(IW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rem_inc),
		.divisor  (thr_rel),
		.busy     (div_busy),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			m_valid_q <= 1'b0;
			ch_q <= '0;
			for (int i = 0; i < NumChannels; i++) begin
				reload_q[i] <= '0;
				count_q[i] <= '0;
				res_q[i] <= '0;
				psel_q[i] <= '0;
				casc_q[i] <= 1'b0;
				irqen_q[i] <= 1'b0;
				en_q[i] <= 1'b0;
			end
		end else begin
			if (m_valid_q && m_tready)
				m_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_op == tcb_pkg::OP_RUN) begin
							ch_q <= '0;
							state_q <= S_RUN;
						end else begin
							ch_q <= CW'(in_ch);
							state_q <= S_ACC;
						end
					end
				end
				S_ACC: begin
					if (op_q == tcb_pkg::OP_WRITE && addr_ok_q) begin
						case (off_q)
							tcb_pkg::OFF_LO: reload_q[ch_q][7:0] <= wdata_q;
							tcb_pkg::OFF_HI: reload_q[ch_q][15:8] <= wdata_q;
							tcb_pkg::OFF_CTRL: begin
								psel_q[ch_q] <= wdata_q[1:0];
								casc_q[ch_q] <= wdata_q[2];
								irqen_q[ch_q] <= wdata_q[6];
								en_q[ch_q] <= wdata_q[7];
								// enable rising: reload and restart prescaler
								if (!en_q[ch_q] && wdata_q[7]) begin
									res_q[ch_q] <= -RW'(2);
									count_q[ch_q] <= cur_rel;
								end
							end
							default: ;
						endcase
					end
					ch_q <= '0;
					state_q <= S_EST;
				end
				S_RUN: begin
					if (en_q[ch_q] && !casc_q[ch_q]) begin
						if (avail[17]) begin
							res_q[ch_q] <= avail[RW-1:0];
							state_q <= S_REC;
						end else begin
							res_q[ch_q] <= RW'(avail[9:0] & tcb_pkg::tick_mask(cur_sel));
							state_q <= S_ADV;
						end
					end else if (ch_q != '0 && en_q[ch_q] && casc_q[ch_q] && carry_q != '0) begin
						state_q <= S_ADV;
					end else begin
						state_q <= S_REC;
					end
				end
				S_ADV: begin
					if (inc_q >= thr) begin
						if (rem_inc >= thr_rel) begin
							state_q <= S_DIV;
						end else begin
							count_q[ch_q] <= cur_rel + rem_inc[15:0];
							state_q <= S_REC;
						end
					end else begin
						count_q[ch_q] <= cur_cnt + inc_q[15:0];
						state_q <= S_REC;
					end
				end
				S_DIV: begin
					if (div_done) begin
						count_q[ch_q] <= cur_rel + div_rem[15:0];
						state_q <= S_REC;
					end
				end
				S_REC: begin
					ch_q <= last_ch ? '0 : ch_q + 1'b1;
					state_q <= last_ch ? S_EST : S_RUN;
				end
				S_EST: begin
					if (last_ch) begin
						ch_q <= '0;
						m_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						ch_q <= ch_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= tcb_pkg::op_t'(in_op);
			off_q <= tcb_pkg::off_t'(in_off);
			wdata_q <= s_tdata[13:6];
			ticks_q <= s_tdata[29:14];
			addr_ok_q <= (32'(in_ch) < NumChannels);
			rd_q <= '0;
			irq_q <= '0;
			ovf0_q <= '0;
			ovf1_q <= '0;
			carry_q <= '0;
			best_ok_q <= 1'b0;
			best_q <= '0;
		end
		case (state_q)
			S_ACC: begin
				if (op_q == tcb_pkg::OP_READ && addr_ok_q) begin
					case (off_q)
						tcb_pkg::OFF_LO: rd_q <= cur_cnt[7:0];
						tcb_pkg::OFF_HI: rd_q <= cur_cnt[15:8];
						tcb_pkg::OFF_CTRL:
							rd_q <= {en_q[ch_q], irqen_q[ch_q], 3'b000, casc_q[ch_q], cur_sel};
						default: rd_q <= '0;
					endcase
				end
			end
			S_RUN: begin
				ovf_q <= '0;
				if (en_q[ch_q] && !casc_q[ch_q])
					inc_q <= avail[IW-1:0] >> cur_shift;
				else
					inc_q <= carry_q;
			end
			S_ADV: begin
				if (inc_q >= thr)
					ovf_q <= IW'(1);
			end
			S_DIV: begin
				if (div_done)
					ovf_q <= div_quot + 1'b1;
			end
			S_REC: begin
				carry_q <= ovf_q;
				if (ovf_q != '0 && irqen_q[ch_q] && 32'(ch_q) < 4)
					irq_q[2'(ch_q)] <= 1'b1;
				if (ch_q == CW'(0))
					ovf0_q <= ovf_q[15:0];
				if (ch_q == CW'(1))
					ovf1_q <= ovf_q[15:0];
			end
			S_EST: begin
				if (cur_due) begin
					best_ok_q <= 1'b1;
					if (!best_ok_q || need_sat < best_q)
						best_q <= need_sat;
				end
				if (last_ch) begin
					m_data_q <= {
						(cur_due && (!best_ok_q || need_sat < best_q)) ? need_sat : best_q,
						best_ok_q || cur_due, ovf1_q, ovf0_q, irq_q, rd_q};
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;

`ifndef SYNTHESIS
	a_ready_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !div_busy)
		else $error("input ready while divider busy");
	a_result_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_EST))
		else $error("result raised outside scan");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (div_busy || div_done))
		else $error("waiting on idle divider");
	a_one_beat_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("second beat taken while busy");
`endif

endmodule
`default_nettype wire
